/* design/gcc_pkg.sv */
// package: shared types and codes for the greedy capacity graph coloring block
package gcc_pkg;
   localparam int MAX_ITEMS  = 64;
   localparam int MAX_COLORS = 64;
   localparam int CAP_WIDTH  = 8;
   typedef enum logic [2:0] {
      FUNC_CONFLICT = 3'd0,
      FUNC_UNAVAIL  = 3'd1,
      FUNC_ATTR     = 3'd2,
      FUNC_CAP      = 3'd3,
      FUNC_START    = 3'd4
   } func_type;
   typedef enum logic [0:0] {
      REG_ITEM_COUNT  = 1'd0,
      REG_COLOR_COUNT = 1'd1
   } reg_index_type;
   localparam logic signed [6:0] NO_COLOR = -7'sd1;
endpackage

/* design/greedy_capacity_graph_coloring.sv */
// top level: greedy capacity-limited graph coloring with memory-held state
// a load is accepted only while idle and gives no result
// a start runs, for each color, a setup, a pass over the items for presets and marks,
// a pass for keys and one descending pass per distinct key of the uncolored items,
// then max(n, c) result beats; a result read waits until the last one is registered
// reset: synchronous, clears control state, presets to uncolored, counts to one
module greedy_capacity_graph_coloring (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_func,
   input  logic [5:0]           req_index,
   input  logic [63:0]          req_row_bits,
   input  logic                 req_is_multi,
   input  logic signed [6:0]    req_preset_color,
   input  logic [7:0]           req_cap_multi,
   input  logic [7:0]           req_cap_single,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [5:0]           rsp_out_index,
   output logic signed [6:0]    rsp_item_color,
   output logic [7:0]           rsp_left_multi,
   output logic [7:0]           rsp_left_single,
   output logic                 rsp_last,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import gcc_pkg::*;

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int KW = 8;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_SETUP = 8'b00000010,
      S_PRE   = 8'b00000100,
      S_KEY   = 8'b00001000,
      S_SCAN  = 8'b00010000,
      S_NEXT  = 8'b00100000,
      S_OUT   = 8'b01000000,
      S_HOLD  = 8'b10000000
   } state_type;

   // memories
   logic [63:0]          conf_mem [MAX_ITEMS];
   logic [63:0]          unav_mem [MAX_ITEMS];
   logic                 kind_mem [MAX_ITEMS];
   logic signed [6:0]    pre_mem  [MAX_ITEMS];
   logic [CAP_WIDTH-1:0] capm_mem [MAX_COLORS];
   logic [CAP_WIDTH-1:0] caps_mem [MAX_COLORS];
   logic [CAP_WIDTH-1:0] remm_mem [MAX_COLORS];
   logic [CAP_WIDTH-1:0] rems_mem [MAX_COLORS];
   logic signed [6:0]    work_mem [MAX_ITEMS];
   logic [KW-1:0]        key_mem  [MAX_ITEMS];

   state_type            state_ff, state_in;
   logic [6:0]           n_ff, c_ff;
   logic [6:0]           cnt_n, cnt_c;
   logic [IW:0]          i_ff, i_in;
   logic [6:0]           col_ff, col_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [IW-1:0]        rd_idx_ff;
   logic [MAX_ITEMS-1:0] marks_ff, marks_in;
   logic [MAX_ITEMS-1:0] open_ff, open_in;
   logic [MAX_ITEMS-1:0] pre_valid_ff;
   logic [CAP_WIDTH-1:0] rm_ff, rm_in, rs_ff, rs_in;
   logic [KW-1:0]        k_ff, k_in, nk_ff, nk_in;
   logic                 nk_has_ff, nk_has_in;
   logic                 first_ff, first_in;
   logic [6:0]           tot;

   logic [63:0]          conf_q, unav_q;
   logic                 kind_q;
   logic signed [6:0]    pre_q, work_q;
   logic [KW-1:0]        key_q;
   logic [CAP_WIDTH-1:0] capm_q, caps_q, remm_q, rems_q;

   logic [IW-1:0]        rd_addr;
   logic                 work_we;
   logic signed [6:0]    work_wd;
   logic                 key_we;
   logic [KW-1:0]        key_wd;
   logic                 rem_we;
   logic [CW-1:0]        col_idx;

   logic [63:0]          imask, cmask;
   logic                 rsp_valid_ff;
   logic [5:0]           o_idx_ff;
   logic signed [6:0]    o_col_ff;
   logic [7:0]           o_lm_ff, o_ls_ff;
   logic                 o_last_ff;
   logic                 out_rd_ff;

   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= 7'd1;
         c_ff <= 7'd1;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_ITEM_COUNT && csr_paddr[1:0] == 2'd0)
            n_ff <= csr_pwdata[6:0];
         else if (csr_paddr[2] == REG_COLOR_COUNT && csr_paddr[1:0] == 2'd0)
            c_ff <= csr_pwdata[6:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == 3'd0)
         csr_prdata[6:0] = n_ff;
      else if (csr_paddr == 3'd4)
         csr_prdata[6:0] = c_ff;
   end

   always_comb begin
      cnt_n = n_ff;
      if (cnt_n == 7'd0) cnt_n = 7'd1;
      if (cnt_n > 7'(MAX_ITEMS)) cnt_n = 7'(MAX_ITEMS);
      cnt_c = c_ff;
      if (cnt_c == 7'd0) cnt_c = 7'd1;
      if (cnt_c > 7'(MAX_COLORS)) cnt_c = 7'(MAX_COLORS);
      tot = (cnt_n > cnt_c) ? cnt_n : cnt_c;
      imask = (cnt_n >= 7'd64) ? '1 : ((64'd1 << cnt_n) - 64'd1);
      cmask = (cnt_c >= 7'd64) ? '1 : ((64'd1 << cnt_c) - 64'd1);
   end

   assign req_ready = (state_ff == S_IDLE);
   logic req_fire;
   assign req_fire = req_valid && req_ready;
   assign col_idx = CW'(col_ff);

   // load writes and reads
   always_ff @(posedge clock) begin
      if (req_fire && req_func == FUNC_CONFLICT && {1'b0, req_index} < 7'(MAX_ITEMS))
         conf_mem[IW'(req_index)] <= req_row_bits;
      if (req_fire && req_func == FUNC_UNAVAIL && {1'b0, req_index} < 7'(MAX_ITEMS))
         unav_mem[IW'(req_index)] <= req_row_bits;
      if (req_fire && req_func == FUNC_ATTR && {1'b0, req_index} < 7'(MAX_ITEMS)) begin
         kind_mem[IW'(req_index)] <= req_is_multi;
         pre_mem[IW'(req_index)]  <= req_preset_color[6] ? NO_COLOR : req_preset_color;
      end
      if (req_fire && req_func == FUNC_CAP && {1'b0, req_index} < 7'(MAX_COLORS)) begin
         capm_mem[CW'(req_index)] <= req_cap_multi[CAP_WIDTH-1:0];
         caps_mem[CW'(req_index)] <= req_cap_single[CAP_WIDTH-1:0];
      end
      conf_q <= conf_mem[rd_addr];
      unav_q <= unav_mem[rd_addr];
      kind_q <= kind_mem[rd_addr];
      pre_q  <= pre_mem[rd_addr];
      capm_q <= capm_mem[CW'(col_in)];
      caps_q <= caps_mem[CW'(col_in)];
   end

   always_ff @(posedge clock) begin
      if (reset)
         pre_valid_ff <= '0;
      else if (req_fire && req_func == FUNC_ATTR && {1'b0, req_index} < 7'(MAX_ITEMS))
         pre_valid_ff[IW'(req_index)] <= 1'b1;
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_addr;
      if (work_we) work_mem[rd_idx_ff] <= work_wd;
      work_q <= work_mem[rd_addr];
      if (key_we) key_mem[rd_idx_ff] <= key_wd;
      key_q <= key_mem[rd_addr];
      if (rem_we) begin
         remm_mem[col_idx] <= rm_ff;
         rems_mem[col_idx] <= rs_ff;
      end
      remm_q <= remm_mem[CW'(i_ff)];
      rems_q <= rems_mem[CW'(i_ff)];
   end

   assign rd_addr = (state_ff == S_SCAN) ? IW'(i_ff - 1'b1) : IW'(i_ff);

   // the item being processed in this cycle is rd_idx_ff, data in *_q
   logic signed [6:0] pre_eff;
   logic              avail;
   logic              has_cap;
   logic [7:0]        key_val;
   logic [63:0]       open64;
   assign pre_eff = pre_valid_ff[rd_idx_ff] ? pre_q : NO_COLOR;
   assign avail   = !unav_q[col_ff[5:0]];
   assign has_cap = kind_q ? (rm_ff != '0) : (rs_ff != '0);
   always_comb begin
      open64 = '0;
      open64[MAX_ITEMS-1:0] = open_ff;
      key_val = 8'($countones(conf_q & open64 & imask)) + 8'($countones(unav_q & cmask));
   end

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      col_in    = col_ff;
      rd_ok_in  = 1'b0;
      marks_in  = marks_ff;
      open_in   = open_ff;
      rm_in     = rm_ff;
      rs_in     = rs_ff;
      k_in      = k_ff;
      nk_in     = nk_ff;
      nk_has_in = nk_has_ff;
      first_in  = first_ff;
      work_we   = 1'b0;
      work_wd   = NO_COLOR;
      key_we    = 1'b0;
      key_wd    = '0;
      rem_we    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_func == FUNC_START) begin
               state_in = S_SETUP;
               col_in   = '0;
               i_in     = '0;
               first_in = 1'b1;
            end
         end
         S_SETUP: begin
            // capacity read is ready now
            rm_in    = capm_q;
            rs_in    = caps_q;
            marks_in = '0;
            open_in  = '0;
            i_in     = '0;
            state_in = S_PRE;
         end
         S_PRE: begin
            // visit items: init work colors on first color, open mask, preset marks
            if (rd_ok_ff) begin
               if (first_ff) begin
                  work_we = 1'b1;
                  work_wd = pre_eff;
               end
               if ((first_ff ? pre_eff : work_q) < 0) begin
                  open_in[rd_idx_ff] = 1'b1;
               end else if (7'((first_ff ? pre_eff : work_q)) == col_ff) begin
                  marks_in = marks_in | (conf_q[MAX_ITEMS-1:0] & imask[MAX_ITEMS-1:0]);
                  if (kind_q) begin
                     if (rm_in != '0) rm_in = rm_ff - 1'b1;
                  end else if (rs_ff != '0) begin
                     rs_in = rs_ff - 1'b1;
                  end
               end
            end
            if (i_ff < (IW+1)'(cnt_n)) begin
               rd_ok_in = 1'b1;
               i_in = i_ff + 1'b1;
            end else if (!rd_ok_ff) begin
               state_in = S_KEY;
               i_in = '0;
               first_in = 1'b0;
            end
         end
         S_KEY: begin
            if (rd_ok_ff) begin
               key_we = 1'b1;
               key_wd = (work_q < 0) ? key_val : '0;
               if (work_q < 0 && (!nk_has_in || key_val > nk_in)) begin
                  nk_in = key_val;
                  nk_has_in = 1'b1;
               end
            end else begin
               nk_has_in = 1'b0;
               nk_in = '0;
            end
            if (i_ff < (IW+1)'(cnt_n)) begin
               rd_ok_in = 1'b1;
               i_in = i_ff + 1'b1;
            end else if (rd_ok_ff) begin
               // nothing
            end else begin
               state_in = nk_has_ff ? S_SCAN : S_NEXT;
               k_in = nk_ff;
               nk_has_in = 1'b0;
               nk_in = '0;
               i_in = (IW+1)'(cnt_n);
            end
         end
         S_SCAN: begin
            // walk descending index for current key k; track next lower key
            if (rd_ok_ff && work_q < 0) begin
               if (key_q == k_ff) begin
                  if (!marks_ff[rd_idx_ff] && avail && has_cap) begin
                     if (kind_q) rm_in = rm_ff - 1'b1;
                     else        rs_in = rs_ff - 1'b1;
                     work_we  = 1'b1;
                     work_wd  = 7'(col_ff);
                     marks_in = marks_ff | (conf_q[MAX_ITEMS-1:0] & imask[MAX_ITEMS-1:0]);
                  end
               end else if (key_q < k_ff && (!nk_has_ff || key_q > nk_ff)) begin
                  nk_in = key_q;
                  nk_has_in = 1'b1;
               end
            end
            if (i_ff != '0) begin
               rd_ok_in = 1'b1;
               i_in = i_ff - 1'b1;
            end else if (!rd_ok_ff) begin
               if (nk_has_ff) begin
                  k_in = nk_ff;
                  nk_has_in = 1'b0;
                  nk_in = '0;
                  i_in = (IW+1)'(cnt_n);
               end else begin
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            rem_we = 1'b1;
            if (col_ff + 7'd1 < cnt_c) begin
               col_in = col_ff + 7'd1;
               i_in = '0;
               state_in = S_SETUP;
            end else begin
               i_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait until no read is pending and the output slot is free, then go to S_HOLD
            if (!out_rd_ff && (!rsp_valid_ff || rsp_ready)) begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (o_last_ff && rsp_valid_ff) begin
                  state_in = S_IDLE;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  state_in = S_HOLD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output sequencing: i_ff walks result indexes, one read per beat
   logic out_issue;
   assign out_issue = (state_ff == S_HOLD) && (i_ff < (IW+1)'(tot)) && !out_rd_ff
                      && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_ok_ff  <= 1'b0;
         out_rd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff <= '0;
         col_ff <= '0;
         first_ff <= 1'b0;
         nk_has_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ok_ff  <= rd_ok_in;
         col_ff    <= col_in;
         first_ff  <= first_in;
         nk_has_ff <= nk_has_in;
         i_ff      <= out_issue ? i_ff + 1'b1 : i_in;
         out_rd_ff <= out_issue;
         if (out_rd_ff)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      marks_ff <= marks_in;
      open_ff  <= open_in;
      rm_ff    <= rm_in;
      rs_ff    <= rs_in;
      k_ff     <= k_in;
      nk_ff    <= nk_in;
      if (out_rd_ff) begin
         o_idx_ff  <= 6'(rd_idx_ff);
         o_col_ff  <= ({1'b0, rd_idx_ff} < 7'(cnt_n)) ? work_q : NO_COLOR;
         o_lm_ff   <= ({1'b0, rd_idx_ff} < 7'(cnt_c)) ? 8'(remm_q) : 8'd0;
         o_ls_ff   <= ({1'b0, rd_idx_ff} < 7'(cnt_c)) ? 8'(rems_q) : 8'd0;
         o_last_ff <= ({1'b0, rd_idx_ff} + 7'd1 == tot);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_index   = o_idx_ff;
   assign rsp_item_color  = o_col_ff;
   assign rsp_left_multi  = o_lm_ff;
   assign rsp_left_single = o_ls_ff;
   assign rsp_last        = o_last_ff;

`ifndef SYNTHESIS
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_rsp_only_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_HOLD || state_ff == S_IDLE))
      else $error("result outside output phase");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
`endif
endmodule

/* tb/greedy_capacity_graph_coloring_tb.sv */
// testbench: greedy capacity graph coloring, checked beat by beat against an in-bench predictor
module greedy_capacity_graph_coloring_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gcc_pkg::*;

   typedef struct packed {
      logic [5:0]        out_index;
      logic signed [6:0] item_color;
      logic [7:0]        left_multi;
      logic [7:0]        left_single;
      logic              last;
   } color_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_func = FUNC_CONFLICT;
   logic [5:0]           req_index = '0;
   logic [63:0]          req_row_bits = '0;
   logic                 req_is_multi = 1'b0;
   logic signed [6:0]    req_preset_color = NO_COLOR;
   logic [7:0]           req_cap_multi = '0;
   logic [7:0]           req_cap_single = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [5:0]           rsp_out_index;
   logic signed [6:0]    rsp_item_color;
   logic [7:0]           rsp_left_multi;
   logic [7:0]           rsp_left_single;
   logic                 rsp_last;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [2:0]           csr_paddr = '0;
   logic [31:0]          csr_pwdata = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   greedy_capacity_graph_coloring DUT (.*);

   always #4 clock = ~clock;

   // predictor state
   logic [63:0]       conflict_rows [64];
   logic [63:0]       unavail_rows [64];
   logic              multi_kind [64];
   logic signed [6:0] preset_of [64];
   logic [7:0]        cap_multi_of [64];
   logic [7:0]        cap_single_of [64];
   logic [6:0]        item_cnt_reg = 7'd1;
   logic [6:0]        color_cnt_reg = 7'd1;

   color_beat_type coloring_q [$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   int          hold_left = 0;
   int          rsp_gap = 0;

   initial begin
      for (int i = 0; i < 64; i++) begin
         conflict_rows[i] = '0;
         unavail_rows[i] = '0;
         multi_kind[i] = 1'b0;
         preset_of[i] = NO_COLOR;
         cap_multi_of[i] = '0;
         cap_single_of[i] = '0;
      end
   end

   function automatic void predict_coloring();
      int n, c, total;
      logic signed [6:0] wc [64];
      int rm [64];
      int rs [64];
      bit marks [64];
      int key [64];
      logic [63:0] imask, cmask, open;
      color_beat_type e;
      n = (item_cnt_reg < 1) ? 1 : (item_cnt_reg > 64) ? 64 : item_cnt_reg;
      c = (color_cnt_reg < 1) ? 1 : (color_cnt_reg > 64) ? 64 : color_cnt_reg;
      imask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      cmask = (c >= 64) ? '1 : ((64'd1 << c) - 64'd1);
      for (int i = 0; i < 64; i++) begin
         wc[i] = (i < n) ? preset_of[i] : NO_COLOR;
         rm[i] = 0;
         rs[i] = 0;
      end
      for (int col = 0; col < c; col++) begin
         rm[col] = cap_multi_of[col];
         rs[col] = cap_single_of[col];
         open = '0;
         for (int i = 0; i < 64; i++) marks[i] = 1'b0;
         for (int i = 0; i < n; i++) if (wc[i] < 0) open[i] = 1'b1;
         for (int i = 0; i < n; i++) begin
            key[i] = 0;
            if (wc[i] < 0) begin
               key[i] = $countones(conflict_rows[i] & open & imask)
                      + $countones(unavail_rows[i] & cmask);
            end else if (wc[i] == col) begin
               for (int j = 0; j < n; j++) if (conflict_rows[i][j]) marks[j] = 1'b1;
               if (multi_kind[i]) begin
                  if (rm[col] > 0) rm[col]--;
               end else begin
                  if (rs[col] > 0) rs[col]--;
               end
            end
         end
         for (int k = 128; k >= 0; k--) begin
            for (int i = n - 1; i >= 0; i--) begin
               bit took;
               took = 1'b0;
               if (key[i] != k || marks[i] || wc[i] >= 0 || unavail_rows[i][col]) continue;
               if (multi_kind[i]) begin
                  if (rm[col] > 0) begin rm[col]--; took = 1'b1; end
               end else begin
                  if (rs[col] > 0) begin rs[col]--; took = 1'b1; end
               end
               if (took) begin
                  wc[i] = 7'(col);
                  for (int j = 0; j < n; j++) if (conflict_rows[i][j]) marks[j] = 1'b1;
               end
            end
         end
      end
      total = (n > c) ? n : c;
      for (int k = 0; k < total; k++) begin
         e.out_index = 6'(k);
         e.item_color = (k < n) ? wc[k] : NO_COLOR;
         e.left_multi = (k < c) ? 8'(rm[k]) : 8'd0;
         e.left_single = (k < c) ? 8'(rs[k]) : 8'd0;
         e.last = (k + 1 == total);
         coloring_q.insert(coloring_q.size(), e);
      end
   endfunction

   task automatic send_beat(input logic [2:0] f, input logic [5:0] idx, input logic [63:0] row,
                            input logic m, input logic [6:0] p, input logic [7:0] cm,
                            input logic [7:0] cs);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_index <= idx;
      req_row_bits <= row;
      req_is_multi <= m;
      req_preset_color <= p;
      req_cap_multi <= cm;
      req_cap_single <= cs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (f)
         FUNC_CONFLICT: conflict_rows[idx] = row;
         FUNC_UNAVAIL:  unavail_rows[idx] = row;
         FUNC_ATTR: begin
            multi_kind[idx] = m;
            preset_of[idx] = p[6] ? NO_COLOR : $signed(p);
         end
         FUNC_CAP: begin
            cap_multi_of[idx] = cm;
            cap_single_of[idx] = cs;
         end
         FUNC_START: predict_coloring();
         default: ;
      endcase
   endtask

   task automatic send_start();
      send_beat(FUNC_START, 6'($urandom), {$urandom, $urandom}, 1'($urandom), 7'($urandom),
                8'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (coloring_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type r, input logic [6:0] v);
      wait_drained();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= {25'd0, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (r == REG_ITEM_COUNT) item_cnt_reg = v;
      else color_cnt_reg = v;
   endtask

   function automatic logic [63:0] rand_row();
      logic [63:0] a, b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: rand_row = a & b;
         1: rand_row = a & b & {$urandom, $urandom};
         2: rand_row = a;
         default: rand_row = a | b;
      endcase
   endfunction

   function automatic logic [7:0] rand_cap();
      case ($urandom_range(0, 7))
         0: rand_cap = 8'd0;
         1: rand_cap = 8'd255;
         2: rand_cap = 8'($urandom);
         default: rand_cap = 8'($urandom_range(0, 3));
      endcase
   endfunction

   // every store entry gets written before any start reads it
   task automatic test_fill();
      for (int i = 0; i < 64; i++) begin
         send_beat(FUNC_CONFLICT, 6'(i), rand_row(), 1'b0, NO_COLOR, 8'd0, 8'd0);
         send_beat(FUNC_UNAVAIL, 6'(i), rand_row() & {$urandom, $urandom}, 1'b0, NO_COLOR,
                   8'd0, 8'd0);
         send_beat(FUNC_ATTR, 6'(i), '0, 1'($urandom),
                   ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 70)) : NO_COLOR,
                   8'd0, 8'd0);
         send_beat(FUNC_CAP, 6'(i), '0, 1'b0, NO_COLOR, rand_cap(), rand_cap());
      end
   endtask

   task automatic test_directed();
      csr_write(REG_ITEM_COUNT, 7'd1);
      csr_write(REG_COLOR_COUNT, 7'd1);
      send_start();
      csr_write(REG_ITEM_COUNT, 7'd8);
      csr_write(REG_COLOR_COUNT, 7'd4);
      send_beat(FUNC_CONFLICT, 6'd0, '1, 1'b0, NO_COLOR, 8'd0, 8'd0);
      send_beat(FUNC_CONFLICT, 6'd63, '0, 1'b0, NO_COLOR, 8'd0, 8'd0);
      send_beat(FUNC_UNAVAIL, 6'd1, '1, 1'b0, NO_COLOR, 8'd0, 8'd0);
      send_beat(FUNC_ATTR, 6'd2, '0, 1'b1, 7'sd63, 8'd0, 8'd0);
      send_beat(FUNC_ATTR, 6'd3, '0, 1'b0, -7'sd64, 8'd0, 8'd0);
      // presets overusing a zero capacity
      send_beat(FUNC_ATTR, 6'd4, '0, 1'b1, 7'sd1, 8'd0, 8'd0);
      send_beat(FUNC_ATTR, 6'd5, '0, 1'b1, 7'sd1, 8'd0, 8'd0);
      send_beat(FUNC_ATTR, 6'd6, '0, 1'b0, 7'sd1, 8'd0, 8'd0);
      send_beat(FUNC_CAP, 6'd1, '0, 1'b0, NO_COLOR, 8'd0, 8'd0);
      send_beat(FUNC_CAP, 6'd0, '0, 1'b0, NO_COLOR, 8'd255, 8'd255);
      send_beat(3'd5, 6'd7, '1, 1'b1, 7'sd5, 8'd9, 8'd9);
      send_beat(3'd6, 6'd7, '1, 1'b1, 7'sd5, 8'd9, 8'd9);
      send_beat(3'd7, 6'd63, '1, 1'b1, 7'sd5, 8'd9, 8'd9);
      send_start();
      csr_write(REG_ITEM_COUNT, 7'd64);
      csr_write(REG_COLOR_COUNT, 7'd64);
      send_start();
   endtask

   task automatic test_pressure();
      csr_write(REG_ITEM_COUNT, 7'd12);
      csr_write(REG_COLOR_COUNT, 7'd40);
      hold_left = 500;
      send_start();
      for (int i = 0; i < 8; i++)
         send_beat(FUNC_CAP, 6'($urandom_range(0, 11)), '0, 1'b0, NO_COLOR, rand_cap(),
                   rand_cap());
      send_start();
      wait_drained();
      send_start();
   endtask

   task automatic test_random();
      logic [6:0] n, c;
      int lim;
      logic [2:0] f;
      for (int r = 0; r < 8; r++) begin
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 11))
            0: begin n = 7'd0; c = 7'd0; end
            1: begin n = 7'd127; c = 7'd2; end
            2: begin n = 7'd3; c = 7'd127; end
            default: begin n = 7'($urandom_range(1, 14)); c = 7'($urandom_range(1, 10)); end
         endcase
         csr_write(REG_ITEM_COUNT, n);
         csr_write(REG_COLOR_COUNT, c);
         lim = (n < 1) ? 1 : (n > 64) ? 64 : n;
         for (int i = 0; i < 16; i++) begin
            f = 3'($urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0) f = 3'($urandom_range(5, 7));
            send_beat(f,
                      ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, lim - 1)),
                      rand_row(), 1'($urandom),
                      ($urandom_range(0, 1) == 0) ? NO_COLOR : 7'($urandom),
                      rand_cap(), rand_cap());
            if ($urandom_range(0, 7) == 0) send_start();
         end
         send_start();
      end
      calm = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (coloring_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat index %0d color %0d", $time, rsp_out_index,
                     rsp_item_color);
         end else begin
            color_beat_type e;
            e = coloring_q.pop_front();
            if (e !== {rsp_out_index, rsp_item_color, rsp_left_multi, rsp_left_single,
                       rsp_last}) begin
               mismatches++;
               $display("%0t: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                        $time, e.out_index, e.item_color, e.left_multi, e.left_single,
                        e.last, rsp_out_index, rsp_item_color, rsp_left_multi,
                        rsp_left_single, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) rsp_gap = calm ? 0 : $urandom_range(0, 6);
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #40ms;
      $display("greedy_capacity_graph_coloring: mismatch");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill();
      test_directed();
      test_pressure();
      test_random();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("greedy_capacity_graph_coloring: match");
      end else begin
         $display("greedy_capacity_graph_coloring: mismatch");
      end
      $finish;
   end
endmodule
